>>> rtl/wnps_pkg.sv
`timescale 1ns / 1ps

package wnps_pkg;

    // Default sizes of the point table and of one coordinate.
    localparam int MAX_POINTS_DEF = 1024;
    localparam int COORD_BITS_DEF = 24;

    // Fixed field widths.
    localparam int CNT_W  = 11;
    localparam int IDX_W  = 10;
    localparam int HINT_W = 11;
    localparam int WIN_W  = 10;
    localparam int WBIT_W = 4;
    localparam int SPAN_W = CNT_W + 2;

    // Configuration port.
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_SEL_BIT = 2;
    localparam logic REG_POINT_COUNT = 1'b0;
    localparam logic REG_CLOSED_LOOP = 1'b1;

    // Request codes.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MOD,
        ST_WRAP,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } seq_state_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic             issue;
        logic [CNT_W-1:0] idx;
        logic             clear_best;
        logic             load_result;
    } seq_ctrl_t;

    // Tag that travels with a point through the distance pipeline.
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] idx;
    } dist_tag_t;

endpackage

>>> rtl/windowed_nearest_point_search.sv
// A write transfer goes straight into the table. A query scans L points (L is
// 2*window+1, clamped to the table on an open path, or the point count) and then presents
// its result; a windowed scan in a closed loop first reduces the window modulo the count,
// and an empty table answers without a scan. One query at a time; the single table read
// port and the shared distance pipeline take one point per cycle. Reset clears the control
// state and both registers; the point table holds no defined value until written.
`timescale 1ns / 1ps

module windowed_nearest_point_search #(
    parameter int MAX_POINTS = wnps_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = wnps_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Item channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                req_type,
    input  logic [wnps_pkg::IDX_W-1:0]          point_index,
    input  logic signed [COORD_BITS-1:0]        loc_x,
    input  logic signed [COORD_BITS-1:0]        loc_y,
    input  logic signed [COORD_BITS-1:0]        loc_z,
    input  logic signed [wnps_pkg::HINT_W-1:0]  hint_index,
    input  logic [wnps_pkg::WIN_W-1:0]          search_window,
    // Result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                found,
    output logic [wnps_pkg::IDX_W-1:0]          nearest_index,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wnps_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [wnps_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [wnps_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CW   = wnps_pkg::CNT_W;
    localparam int SUMW = 2 * COORD_BITS + 3;

    logic [CW-1:0] point_count_reg;
    logic          closed_loop_reg;
    logic [CW-1:0] n_eff;
    logic          cfg_write;

    logic          in_acc;
    logic          ram_we;
    logic [3*COORD_BITS-1:0] ram_rdata;

    logic signed [COORD_BITS-1:0] qx_reg, qy_reg, qz_reg;

    wnps_pkg::seq_ctrl_t ctrl;
    wnps_pkg::dist_tag_t issue_tag;
    wnps_pkg::dist_tag_t dist_tag;
    logic [SUMW-1:0]     dist_sum;
    logic                pipe_busy;

    logic            have_reg;
    logic [SUMW-1:0] best_d_reg;
    logic [CW-1:0]   best_i_reg;

    logic                       out_valid_reg;
    logic                       found_reg;
    logic [wnps_pkg::IDX_W-1:0] nearest_index_reg;
    logic                       out_free;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
            closed_loop_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (paddr[wnps_pkg::REG_SEL_BIT])
                wnps_pkg::REG_POINT_COUNT: point_count_reg <= pwdata[CW-1:0];
                wnps_pkg::REG_CLOSED_LOOP: closed_loop_reg <= pwdata[0];
                default:                   point_count_reg <= point_count_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[wnps_pkg::REG_SEL_BIT])
            wnps_pkg::REG_POINT_COUNT: prdata = wnps_pkg::APB_DATA_W'(point_count_reg);
            wnps_pkg::REG_CLOSED_LOOP: prdata = wnps_pkg::APB_DATA_W'(closed_loop_reg);
            default:                   prdata = '0;
        endcase
    end

    // Point count limited to the table size.
    assign n_eff = (32'(point_count_reg) > MAX_POINTS) ? CW'(MAX_POINTS) : point_count_reg;

    // Write transfers go straight into the table.
    assign in_acc = in_valid && in_ready;
    assign ram_we = in_acc && (req_type == wnps_pkg::REQ_WRITE)
                    && (32'(point_index) < MAX_POINTS);

    wnps_ram #(
        .WIDTH (3 * COORD_BITS),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(point_index)),
        .wdata ({loc_z, loc_y, loc_x}),
        .raddr (AW'(ctrl.idx)),
        .rdata (ram_rdata)
    );

    // Query location held for the whole scan.
    always_ff @(posedge clk)
    begin
        if (in_acc && (req_type == wnps_pkg::REQ_QUERY))
        begin
            qx_reg <= loc_x;
            qy_reg <= loc_y;
            qz_reg <= loc_z;
        end
    end

    wnps_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .req_type      (req_type),
        .hint_index    (hint_index),
        .search_window (search_window),
        .n_eff         (n_eff),
        .closed        (closed_loop_reg),
        .pipe_busy     (pipe_busy),
        .out_free      (out_free),
        .in_ready      (in_ready),
        .ctrl          (ctrl)
    );

    assign issue_tag.valid = ctrl.issue;
    assign issue_tag.idx   = ctrl.idx;

    wnps_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .issue (issue_tag),
        .rdata (ram_rdata),
        .qx    (qx_reg),
        .qy    (qy_reg),
        .qz    (qz_reg),
        .tag   (dist_tag),
        .sum   (dist_sum),
        .busy  (pipe_busy)
    );

    // Running minimum; a strict compare keeps the first point scanned on a tie.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else if (ctrl.clear_best)
        begin
            have_reg <= 1'b0;
        end
        else if (dist_tag.valid)
        begin
            have_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dist_tag.valid && (!have_reg || (dist_sum < best_d_reg)))
        begin
            best_d_reg <= dist_sum;
            best_i_reg <= dist_tag.idx;
        end
    end

    // Output register frees the sequencer while a result waits.
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_result)
        begin
            found_reg         <= have_reg;
            nearest_index_reg <= have_reg ? best_i_reg[wnps_pkg::IDX_W-1:0] : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign nearest_index = nearest_index_reg;

endmodule

>>> rtl/wnps_ram.sv
`timescale 1ns / 1ps

module wnps_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/wnps_dist.sv
`timescale 1ns / 1ps

module wnps_dist #(
    parameter int COORD_BITS = wnps_pkg::COORD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  wnps_pkg::dist_tag_t         issue,
    input  logic [3*COORD_BITS-1:0]     rdata,
    input  logic signed [COORD_BITS-1:0] qx,
    input  logic signed [COORD_BITS-1:0] qy,
    input  logic signed [COORD_BITS-1:0] qz,
    output wnps_pkg::dist_tag_t         tag,
    output logic [2*COORD_BITS+2:0]     sum,
    output logic                        busy
);

    localparam int DW   = COORD_BITS + 1;
    localparam int SQW  = 2 * COORD_BITS + 1;
    localparam int SUMW = 2 * COORD_BITS + 3;

    wnps_pkg::dist_tag_t t1_reg, t2_reg, t3_reg, t4_reg, t5_reg;

    logic signed [COORD_BITS-1:0] px, py, pz;
    logic signed [DW-1:0]         dx, dy, dz;
    logic [DW-1:0]                ax_reg, ay_reg, az_reg;
    logic [2*DW-1:0]              prod_x, prod_y, prod_z;
    logic [SQW-1:0]               sqx_reg, sqy_reg, sqz_reg;
    logic [SQW-1:0]               sqz4_reg;
    logic [SUMW-1:0]              sxy_reg, sum_reg;

    // Stored point as laid out in the table word.
    assign px = rdata[COORD_BITS-1:0];
    assign py = rdata[2*COORD_BITS-1:COORD_BITS];
    assign pz = rdata[3*COORD_BITS-1:2*COORD_BITS];

    // Signed differences, one bit wider than a coordinate.
    assign dx = DW'(px) - DW'(qx);
    assign dy = DW'(py) - DW'(qy);
    assign dz = DW'(pz) - DW'(qz);

    assign prod_x = ax_reg * ax_reg;
    assign prod_y = ay_reg * ay_reg;
    assign prod_z = az_reg * az_reg;

    // Valid bits of the stages; the first stage lines up with the table read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg <= '0;
            t2_reg <= '0;
            t3_reg <= '0;
            t4_reg <= '0;
            t5_reg <= '0;
        end
        else
        begin
            t1_reg <= issue;
            t2_reg <= t1_reg;
            t3_reg <= t2_reg;
            t4_reg <= t3_reg;
            t5_reg <= t4_reg;
        end
    end

    // Absolute differences, squares, then a two-step sum.
    always_ff @(posedge clk)
    begin
        ax_reg   <= dx[DW-1] ? DW'(-dx) : DW'(dx);
        ay_reg   <= dy[DW-1] ? DW'(-dy) : DW'(dy);
        az_reg   <= dz[DW-1] ? DW'(-dz) : DW'(dz);
        sqx_reg  <= prod_x[SQW-1:0];
        sqy_reg  <= prod_y[SQW-1:0];
        sqz_reg  <= prod_z[SQW-1:0];
        sxy_reg  <= SUMW'(sqx_reg) + SUMW'(sqy_reg);
        sqz4_reg <= sqz_reg;
        sum_reg  <= sxy_reg + SUMW'(sqz4_reg);
    end

    assign tag  = t5_reg;
    assign sum  = sum_reg;
    assign busy = t1_reg.valid | t2_reg.valid | t3_reg.valid | t4_reg.valid | t5_reg.valid;

endmodule

>>> rtl/wnps_seq.sv
`timescale 1ns / 1ps

module wnps_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              req_type,
    input  logic signed [wnps_pkg::HINT_W-1:0] hint_index,
    input  logic [wnps_pkg::WIN_W-1:0]        search_window,
    input  logic [wnps_pkg::CNT_W-1:0]        n_eff,
    input  logic                              closed,
    input  logic                              pipe_busy,
    input  logic                              out_free,
    output logic                              in_ready,
    output wnps_pkg::seq_ctrl_t               ctrl
);

    localparam int CW = wnps_pkg::CNT_W;
    localparam int SW = wnps_pkg::SPAN_W;
    localparam int IW = wnps_pkg::IDX_W;

    wnps_pkg::seq_state_t state_reg, state_next;

    logic [wnps_pkg::HINT_W-1:0] hint_reg, hint_next;
    logic [wnps_pkg::WIN_W-1:0]  win_reg, win_next;
    logic [CW-1:0]               idx_reg, idx_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic [CW-1:0]               rem_reg, rem_next;
    logic [wnps_pkg::WBIT_W-1:0] bit_reg, bit_next;

    logic          query_acc;
    logic          hint_ok;
    logic [CW-1:0] n_last;
    logic [SW-1:0] open_first, open_last;
    logic [CW-1:0] open_start, open_end, open_cnt;
    logic [CW:0]   mod_trial, mod_sub;
    logic [CW-1:0] mod_rem;
    logic [CW:0]   wrap_diff, wrap_sum;
    logic [CW-1:0] wrap_start;
    logic [CW-1:0] scan_next_idx;

    assign in_ready  = (state_reg == wnps_pkg::ST_IDLE);
    assign query_acc = in_valid && in_ready && (req_type == wnps_pkg::REQ_QUERY);
    assign n_last    = n_eff - CW'(1);

    // The hint counts only inside the table and with a nonzero window.
    assign hint_ok = !hint_reg[wnps_pkg::HINT_W-1]
                     && (CW'(hint_reg[IW-1:0]) < n_eff)
                     && (win_reg != '0);

    // Open path: clamp the window to the table.
    assign open_first = SW'(hint_reg[IW-1:0]) - SW'(win_reg);
    assign open_last  = SW'(hint_reg[IW-1:0]) + SW'(win_reg);
    assign open_start = open_first[SW-1] ? '0 : open_first[CW-1:0];
    assign open_end   = (open_last > SW'(n_last)) ? n_last : open_last[CW-1:0];
    assign open_cnt   = open_end - open_start + CW'(1);

    // Closed loop: window modulo count, one window bit per cycle.
    assign mod_trial = {rem_reg, win_reg[bit_reg]};
    assign mod_sub   = mod_trial - (CW+1)'(n_eff);
    assign mod_rem   = (mod_trial >= (CW+1)'(n_eff)) ? mod_sub[CW-1:0] : mod_trial[CW-1:0];

    // First scanned slot of a wrapped window.
    assign wrap_diff  = (CW+1)'(hint_reg[IW-1:0]) - (CW+1)'(rem_reg);
    assign wrap_sum   = wrap_diff + (CW+1)'(n_eff);
    assign wrap_start = wrap_diff[CW] ? wrap_sum[CW-1:0] : wrap_diff[CW-1:0];

    assign scan_next_idx = (closed && (idx_reg == n_last)) ? '0 : idx_reg + CW'(1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wnps_pkg::ST_IDLE:
            begin
                if (query_acc)
                begin
                    state_next = wnps_pkg::ST_SETUP;
                end
            end
            wnps_pkg::ST_SETUP:
            begin
                if (n_eff == '0)
                begin
                    state_next = wnps_pkg::ST_FINISH;
                end
                else if (hint_ok && closed)
                begin
                    state_next = wnps_pkg::ST_MOD;
                end
                else
                begin
                    state_next = wnps_pkg::ST_SCAN;
                end
            end
            wnps_pkg::ST_MOD:
            begin
                if (bit_reg == '0)
                begin
                    state_next = wnps_pkg::ST_WRAP;
                end
            end
            wnps_pkg::ST_WRAP:
            begin
                state_next = wnps_pkg::ST_SCAN;
            end
            wnps_pkg::ST_SCAN:
            begin
                if (cnt_reg == CW'(1))
                begin
                    state_next = wnps_pkg::ST_DRAIN;
                end
            end
            wnps_pkg::ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = wnps_pkg::ST_FINISH;
                end
            end
            wnps_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = wnps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wnps_pkg::ST_IDLE;
            end
        endcase
    end

    // Scan bounds, remainder and index counters.
    always_comb
    begin
        hint_next = hint_reg;
        win_next  = win_reg;
        idx_next  = idx_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        bit_next  = bit_reg;
        case (state_reg)
            wnps_pkg::ST_IDLE:
            begin
                if (query_acc)
                begin
                    hint_next = hint_index;
                    win_next  = search_window;
                end
            end
            wnps_pkg::ST_SETUP:
            begin
                rem_next = '0;
                bit_next = wnps_pkg::WBIT_W'(wnps_pkg::WIN_W - 1);
                if (!hint_ok)
                begin
                    idx_next = '0;
                    cnt_next = n_eff;
                end
                else if (!closed)
                begin
                    idx_next = open_start;
                    cnt_next = open_cnt;
                end
            end
            wnps_pkg::ST_MOD:
            begin
                rem_next = mod_rem;
                bit_next = bit_reg - wnps_pkg::WBIT_W'(1);
            end
            wnps_pkg::ST_WRAP:
            begin
                idx_next = wrap_start;
                cnt_next = {win_reg, 1'b1};
            end
            wnps_pkg::ST_SCAN:
            begin
                idx_next = scan_next_idx;
                cnt_next = cnt_reg - CW'(1);
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        ctrl.issue       = (state_reg == wnps_pkg::ST_SCAN);
        ctrl.idx         = idx_reg;
        ctrl.clear_best  = query_acc;
        ctrl.load_result = (state_reg == wnps_pkg::ST_FINISH) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wnps_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hint_reg <= hint_next;
        win_reg  <= win_next;
        idx_reg  <= idx_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        bit_reg  <= bit_next;
    end

endmodule

>>> rtl/wnps_checker.sv
`timescale 1ns / 1ps

module wnps_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       req_type,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       found,
    input logic [wnps_pkg::IDX_W-1:0] nearest_index
);

    // A result that reports nothing found carries index zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> nearest_index == '0)
        else $error("nearest_index nonzero while found is low");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found) && $stable(nearest_index))
        else $error("result changed while stalled");

    // The block is busy in the cycle after it takes a query.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (req_type == wnps_pkg::REQ_QUERY) |=> !in_ready)
        else $error("query transfer did not make the block busy");

    // A new result appears only at the end of a query, never after an idle cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while the block was idle");

endmodule

bind windowed_nearest_point_search wnps_checker u_wnps_checker (.*);
